// ===== design/block_store_free_list_allocator_macros.svh =====
// Assertion macros used by the slot allocator back end.
`ifndef BLOCK_STORE_FREE_LIST_ALLOCATOR_MACROS_SVH
`define BLOCK_STORE_FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Condition must never hold at a clock edge.
`define BSFL_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
// Antecedent implies consequent in the same cycle.
`define BSFL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
// Antecedent implies consequent in the next cycle.
`define BSFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define BSFL_ASSERT_NEVER(label, clk, rst_n, cond)
`define BSFL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BSFL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/bsfl_pkg.sv =====
// Types and constants shared by the slot allocator modules.
`default_nettype none
package bsfl_pkg;

    // slot field is 6 bits wide, so no more than this many slots are addressable
    localparam int SLOT_LIMIT = 64;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // configuration port
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] REG_SLOT_COUNT  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_BLOCK_BYTES = 2'd1;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NO_SPACE  = 3'd1,
        STS_BAD_INDEX = 3'd2,
        STS_DISABLED  = 3'd3,
        STS_OVERFLOW  = 3'd4
    } t_status;

    // class given to a word by the front end
    typedef enum logic [1:0] {
        K_PUT    = 2'd0,
        K_GET    = 2'd1,
        K_REMOVE = 2'd2,
        K_REJECT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [5:0]  slot;
        logic [7:0]  data;
        logic        byte_valid;
        logic        last;
    } t_item;

    // effective configuration and busy flag seen by the front end
    typedef struct packed {
        logic [6:0]  slots;
        logic [6:0]  bytes;
        logic        clearing;
    } t_cfg_view;

    typedef struct packed {
        t_status     status;
        logic [5:0]  slot;
        logic        slot_valid;
        logic [7:0]  rbyte;
        logic        last;
        logic [12:0] used;
    } t_result;

    function automatic logic [6:0] clamp7(input logic [6:0] v, input logic [6:0] lim);
        clamp7 = (v > lim) ? lim : v;
    endfunction

endpackage
`default_nettype wire

// ===== design/block_store_free_list_allocator.sv =====
// Top level of the LIFO free-list slot allocator with its block store.
// Input channel (i_in_valid / o_in_stall) carries one command word per cycle when not
// stalled: put byte, get block or remove slot. Output channel (o_out_valid / i_out_stall)
// returns result words; a put run answers only on its closing word, a get answers with
// one word per block byte, every other command but a nop with exactly one word.
// Path: an accepted word goes through the queue, then its result through the result stage
// and the output register; a get first enters the get state and reads the block store.
// Throughput: one word per cycle while nothing stalls. The first word of a put run stalls
// after any stack change, until the registered top-of-stack read is current again.
// A get holds the back end to take the word and then one byte per cycle, when the result
// stage is free, from the store's single read port, while the front keeps filling its
// four-word queue.
// Reset: the block store, NUM_SLOTS*MAX_BLOCK_BYTES bytes (4096 with defaults, NUM_SLOTS
// capped at 64), is zeroed one byte per cycle with o_in_stall high; register writes
// are taken meanwhile. A register write rebuilds the free stack and ends any put run.
// When i_out_stall is high the output word holds; one more result waits in the stage
// behind it and the queue takes further words until it is full.
`default_nettype none
module block_store_free_list_allocator import bsfl_pkg::*; #(
    parameter int NUM_SLOTS       = 64,
    parameter int MAX_BLOCK_BYTES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [6:0]        i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [5:0]        i_slot,
    input  wire logic              i_slot_valid,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_byte_valid,
    input  wire logic              i_last,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [2:0]             o_status,
    output logic [5:0]             o_slot_out,
    output logic                   o_slot_out_valid,
    output logic [7:0]             o_read_byte,
    output logic                   o_last_out,
    output logic [12:0]            o_bytes_used
);

    t_cfg_view cfg_view;
    t_item     push_item, head_item;
    logic      push, q_full, q_vld, q_pop;
    t_result   res;

    bsfl_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_slot       (i_slot),
        .i_slot_valid (i_slot_valid),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .i_cfg        (cfg_view),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_item       (push_item)
    );

    bsfl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_head  (head_item),
        .i_pop   (q_pop)
    );

    bsfl_back #(
        .NUM_SLOTS       (NUM_SLOTS),
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg_view),
        .i_q_vld     (q_vld),
        .i_q_head    (head_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    // split the result word onto its ports
    assign o_status         = res.status;
    assign o_slot_out       = res.slot;
    assign o_slot_out_valid = res.slot_valid;
    assign o_read_byte      = res.rbyte;
    assign o_last_out       = res.last;
    assign o_bytes_used     = res.used;

endmodule
`default_nettype wire

// ===== design/bsfl_front.sv =====
// Front end: takes input words and classifies them for the back end.
`default_nettype none
module bsfl_front import bsfl_pkg::*; (
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_cmd,
    input  wire logic [5:0] i_slot,
    input  wire logic       i_slot_valid,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_byte_valid,
    input  wire logic       i_last,
    input  wire t_cfg_view  i_cfg,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_item           o_item
);

    logic keep;

    // hold off while the queue is full or the store is being cleared
    assign o_in_stall = i_q_full || i_cfg.clearing;

    // classify; checks that need only the configuration are settled here
    always_comb begin
        o_item = '{kind: K_REJECT, status: STS_DISABLED, slot: i_slot,
                   data: i_data_byte, byte_valid: i_byte_valid, last: i_last};
        keep   = 1'b0;
        unique case (t_cmd'(i_cmd))
            CMD_PUT: begin
                if (i_cfg.bytes == 7'd0) begin
                    // disabled store: only the closing word answers
                    keep = i_last;
                end else begin
                    o_item.kind = K_PUT;
                    keep        = 1'b1;
                end
            end
            CMD_GET, CMD_REMOVE: begin
                keep = 1'b1;
                if (i_cfg.bytes == 7'd0 || !i_slot_valid) begin
                    o_item.status = STS_DISABLED;
                end else if ({1'b0, i_slot} >= i_cfg.slots) begin
                    o_item.status = STS_BAD_INDEX;
                end else begin
                    o_item.kind = (t_cmd'(i_cmd) == CMD_GET) ? K_GET : K_REMOVE;
                end
            end
            CMD_NOP: keep = 1'b0;
        endcase
    end

    assign o_push = i_in_valid && !o_in_stall && keep;

endmodule
`default_nettype wire

// ===== design/bsfl_queue.sv =====
// Short queue of classified words between front and back end.
`default_nettype none
module bsfl_queue import bsfl_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_vld,
    output t_item      o_head,
    input  wire logic  i_pop
);

    t_item            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr, r_rd;
    logic [Q_AW:0]    r_cnt;

    assign o_full = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_head = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

endmodule
`default_nettype wire

// ===== design/bsfl_back.sv =====
// Back end: free stack, block store, put/get/remove sequencing and result stages.
`default_nettype none
`include "block_store_free_list_allocator_macros.svh"
module bsfl_back import bsfl_pkg::*; #(
    parameter int NUM_SLOTS       = 64,
    parameter int MAX_BLOCK_BYTES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [6:0]        i_cfg_data,
    output t_cfg_view              o_cfg,
    input  wire logic              i_q_vld,
    input  wire t_item             i_q_head,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_result                o_res
);

    localparam int SLOTS_EFF = (NUM_SLOTS < SLOT_LIMIT) ? NUM_SLOTS : SLOT_LIMIT;
    localparam int SW        = (SLOTS_EFF > 1) ? $clog2(SLOTS_EFF) : 1;
    localparam int DEPTH     = SLOTS_EFF * MAX_BLOCK_BYTES;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [6:0] SLOTS_MAX = 7'(SLOTS_EFF);
    localparam logic [6:0] BYTES_MAX = 7'(MAX_BLOCK_BYTES);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_GET} t_state;

    function automatic logic [AW-1:0] data_addr(input logic [5:0] s, input logic [6:0] o);
        data_addr = AW'(s) * AW'(MAX_BLOCK_BYTES) + AW'(o);
    endfunction

    // storage
    logic [5:0] stack_mem [SLOTS_EFF];
    logic [7:0] data_mem  [DEPTH];

    // control state
    t_state       r_state, n_state;
    logic [6:0]   r_reg_sc, n_reg_sc, r_reg_bb, n_reg_bb;
    logic [6:0]   r_fc, n_fc;
    logic [6:0]   r_low, n_low;            // lowest stack index pushed since rebuild
    logic         r_top_ok, n_top_ok;
    logic [5:0]   r_top_data;
    logic         r_put_active, n_put_active;
    logic [5:0]   r_put_slot, n_put_slot;
    logic [6:0]   r_put_off, n_put_off;
    logic         r_put_failed, n_put_failed;
    logic [AW-1:0] r_clr, n_clr;
    logic [5:0]   r_get_slot, n_get_slot;
    logic [6:0]   r_get_idx, n_get_idx;
    logic         r_s1_vld, n_s1_vld;
    logic         r_out_vld, n_out_vld;

    // payload
    t_result      r_s1, r_out;
    logic         r_s1_get;
    logic [7:0]   r_rd_data;
    t_result      out_res;

    // datapath strobes
    logic          st_we;
    logic [SW-1:0] st_waddr;
    logic [5:0]    st_wdata;
    logic          d_we;
    logic [AW-1:0] d_waddr;
    logic [7:0]    d_wdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          s1_load, s1_get;
    t_result       s1_res;
    logic          top_used;
    logic          cfg_hit;

    logic [6:0]  sc, bb, top_idx;
    logic [5:0]  top_val, cur_slot;
    logic [6:0]  cur_off;
    logic        cur_failed;
    logic [13:0] prod;
    logic        out_free, s1_free, s1_move, can_put;

    assign sc = clamp7(r_reg_sc, SLOTS_MAX);
    assign bb = clamp7(r_reg_bb, BYTES_MAX);
    assign o_cfg = '{slots: sc, bytes: bb, clearing: (r_state == ST_CLEAR)};

    // result pipeline handshake
    assign out_free = !r_out_vld || !i_out_stall;
    assign s1_move  = r_s1_vld && out_free;
    assign s1_free  = !r_s1_vld || out_free;

    // top of stack: untouched entries still hold the rebuilt order
    assign top_idx = (r_fc == 7'd0) ? 7'd0 : r_fc - 7'd1;
    assign top_val = (top_idx >= r_low) ? r_top_data : 6'(sc - 7'd1 - top_idx);

    assign cfg_hit = i_cfg_we &&
                     (i_cfg_index == REG_SLOT_COUNT || i_cfg_index == REG_BLOCK_BYTES);

    // read data joins the get result on its way out
    always_comb begin
        out_res       = r_s1;
        out_res.rbyte = r_s1_get ? r_rd_data : 8'd0;
    end

    // sequencing
    always_comb begin
        n_state      = r_state;
        n_reg_sc     = r_reg_sc;
        n_reg_bb     = r_reg_bb;
        n_fc         = r_fc;
        n_low        = r_low;
        n_put_active = r_put_active;
        n_put_slot   = r_put_slot;
        n_put_off    = r_put_off;
        n_put_failed = r_put_failed;
        n_clr        = r_clr;
        n_get_slot   = r_get_slot;
        n_get_idx    = r_get_idx;
        o_q_pop      = 1'b0;
        st_we        = 1'b0;
        st_waddr     = r_fc[SW-1:0];
        st_wdata     = i_q_head.slot;
        d_we         = 1'b0;
        d_waddr      = r_clr;
        d_wdata      = 8'd0;
        rd_en        = 1'b0;
        rd_addr      = data_addr(r_get_slot, r_get_idx);
        s1_load      = 1'b0;
        s1_get       = 1'b0;
        s1_res       = '{status: STS_OK, slot: 6'd0, slot_valid: 1'b0, rbyte: 8'd0,
                         last: 1'b1, used: 13'd0};
        top_used     = 1'b0;
        cur_slot     = r_put_slot;
        cur_off      = r_put_off;
        cur_failed   = r_put_failed;
        can_put      = (r_put_active || r_fc == 7'd0 || r_top_ok) &&
                       (!i_q_head.last || s1_free);

        unique case (r_state)
            ST_CLEAR: begin
                // zero the block store, one byte a cycle
                d_we  = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_q_vld) begin
                    unique case (i_q_head.kind)
                        K_REJECT: begin
                            if (s1_free) begin
                                o_q_pop       = 1'b1;
                                s1_load       = 1'b1;
                                s1_res.status = i_q_head.status;
                            end
                        end
                        K_REMOVE: begin
                            if (s1_free) begin
                                o_q_pop           = 1'b1;
                                s1_load           = 1'b1;
                                s1_res.slot       = i_q_head.slot;
                                s1_res.slot_valid = 1'b1;
                                if (r_fc >= sc) begin
                                    s1_res.status = STS_OVERFLOW;
                                end else begin
                                    st_we = 1'b1;
                                    n_fc  = r_fc + 7'd1;
                                    if (r_fc < r_low) n_low = r_fc;
                                end
                            end
                        end
                        K_GET: begin
                            o_q_pop    = 1'b1;
                            n_state    = ST_GET;
                            n_get_slot = i_q_head.slot;
                            n_get_idx  = 7'd0;
                        end
                        K_PUT: begin
                            if (can_put) begin
                                o_q_pop = 1'b1;
                                // first word of a run pops a slot
                                if (!r_put_active) begin
                                    cur_off = 7'd0;
                                    if (r_fc == 7'd0) begin
                                        cur_failed = 1'b1;
                                        cur_slot   = 6'd0;
                                    end else begin
                                        top_used   = 1'b1;
                                        cur_failed = 1'b0;
                                        cur_slot   = top_val;
                                        n_fc       = r_fc - 7'd1;
                                    end
                                end
                                n_put_active = 1'b1;
                                n_put_slot   = cur_slot;
                                n_put_failed = cur_failed;
                                n_put_off    = cur_off;
                                if (i_q_head.byte_valid) begin
                                    if (!cur_failed && cur_off < bb) begin
                                        d_we    = 1'b1;
                                        d_waddr = data_addr(cur_slot, cur_off);
                                        d_wdata = i_q_head.data;
                                    end
                                    if (cur_off < BYTES_MAX) n_put_off = cur_off + 7'd1;
                                end
                                // closing word reports the slot, or no space if none was free
                                if (i_q_head.last) begin
                                    n_put_active = 1'b0;
                                    n_put_off    = 7'd0;
                                    n_put_failed = 1'b0;
                                    s1_load      = 1'b1;
                                    if (cur_failed) begin
                                        s1_res.status = STS_NO_SPACE;
                                    end else begin
                                        s1_res.slot       = cur_slot;
                                        s1_res.slot_valid = 1'b1;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            ST_GET: begin
                // stream the block, one byte a cycle while the result stage is free
                if (s1_free) begin
                    rd_en             = 1'b1;
                    s1_load           = 1'b1;
                    s1_get            = 1'b1;
                    s1_res.slot       = r_get_slot;
                    s1_res.slot_valid = 1'b1;
                    s1_res.last       = (r_get_idx + 7'd1 == bb);
                    n_get_idx         = r_get_idx + 7'd1;
                    if (s1_res.last) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // register write rebuilds the stack and ends any put run
        if (cfg_hit) begin
            if (i_cfg_index == REG_SLOT_COUNT) n_reg_sc = i_cfg_data;
            else                               n_reg_bb = i_cfg_data;
            n_fc         = clamp7(n_reg_sc, SLOTS_MAX);
            n_low        = n_fc;
            n_put_active = 1'b0;
            n_put_slot   = 6'd0;
            n_put_off    = 7'd0;
            n_put_failed = 1'b0;
        end

        // bytes in use after this word
        prod        = 14'(sc - n_fc) * 14'(bb);
        s1_res.used = prod[12:0];

        n_top_ok  = (n_fc == r_fc) && !cfg_hit;
        n_s1_vld  = s1_load || (r_s1_vld && !s1_move);
        n_out_vld = s1_move || (r_out_vld && i_out_stall);
    end

    // control registers, result stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_reg_sc     <= 7'd64;
            r_reg_bb     <= 7'd64;
            r_fc         <= SLOTS_MAX;
            r_low        <= SLOTS_MAX;
            r_top_ok     <= 1'b0;
            r_put_active <= 1'b0;
            r_put_slot   <= 6'd0;
            r_put_off    <= 7'd0;
            r_put_failed <= 1'b0;
            r_clr        <= '0;
            r_get_slot   <= 6'd0;
            r_get_idx    <= 7'd0;
            r_s1_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_reg_sc     <= n_reg_sc;
            r_reg_bb     <= n_reg_bb;
            r_fc         <= n_fc;
            r_low        <= n_low;
            r_top_ok     <= n_top_ok;
            r_put_active <= n_put_active;
            r_put_slot   <= n_put_slot;
            r_put_off    <= n_put_off;
            r_put_failed <= n_put_failed;
            r_clr        <= n_clr;
            r_get_slot   <= n_get_slot;
            r_get_idx    <= n_get_idx;
            r_s1_vld     <= n_s1_vld;
            r_out_vld    <= n_out_vld;
            if (s1_load) begin
                r_s1     <= s1_res;
                r_s1_get <= s1_get;
            end
            if (s1_move) r_out <= out_res;
        end
    end

    // free stack memory, top read every cycle
    always_ff @(posedge i_clk) begin
        if (st_we) stack_mem[st_waddr] <= st_wdata;
        r_top_data <= stack_mem[top_idx[SW-1:0]];
    end

    // block store memory
    always_ff @(posedge i_clk) begin
        if (d_we) data_mem[d_waddr] <= d_wdata;
        if (rd_en) r_rd_data <= data_mem[rd_addr];
    end

    assign o_out_valid = r_out_vld;
    assign o_res       = r_out;

    `BSFL_ASSERT_NEVER(a_fc_bound, i_clk, i_rst_n, r_fc > sc)
    `BSFL_ASSERT_IMPLIES(a_top_fresh, i_clk, i_rst_n, top_used, r_top_ok)
    `BSFL_ASSERT_NEVER(a_no_pop_clear, i_clk, i_rst_n, o_q_pop && r_state == ST_CLEAR)
    `BSFL_ASSERT_NEXT(a_get_ends, i_clk, i_rst_n, s1_load && s1_get && s1_res.last, r_state == ST_IDLE)

endmodule
`default_nettype wire
